@@ hdl/cfps_pkg.sv @@
// Package for the click-free pulse period write sequencer.
// Beat types, microcode word layout and the microcode table. No dependencies.
package cfps_pkg;

    // Request beat: one period update.
    typedef struct packed {
        logic [10:0] new_period;
        logic        force_req;
        logic        notes_active;
        logic [3:0]  volume;
        logic [1:0]  duty;
    } req_beat_t;

    // Write beat: one sound chip register write.
    typedef struct packed {
        logic [4:0] reg_addr;
        logic [7:0] reg_data;
        logic       last;
    } wr_beat_t;

    // Step addresses of the microprogram.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_CTRL = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HI   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SW0  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SW1  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SW2  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SW3  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SW4  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LO   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_END  = 4'd8;

    // Data source selects.
    localparam logic [2:0] DSEL_CONST = 3'd0;
    localparam logic [2:0] DSEL_CTRL  = 3'd1;
    localparam logic [2:0] DSEL_HI    = 3'd2;
    localparam logic [2:0] DSEL_LO    = 3'd3;
    localparam logic [2:0] DSEL_DIR6  = 3'd4;
    localparam logic [2:0] DSEL_DIR5  = 3'd5;

    // Jump conditions.
    localparam logic [1:0] JMP_NEVER  = 2'd0;
    localparam logic [1:0] JMP_ALWAYS = 2'd1;
    localparam logic [1:0] JMP_SAME   = 2'd2;
    localparam logic [1:0] JMP_MORE   = 2'd3;

    // Register offsets.
    localparam logic [4:0] ADDR_CTRL  = 5'h04;
    localparam logic [4:0] ADDR_SWEEP = 5'h05;
    localparam logic [4:0] ADDR_LO    = 5'h06;
    localparam logic [4:0] ADDR_HI    = 5'h07;
    localparam logic [4:0] ADDR_FRAME = 5'h17;
    localparam logic [4:0] ADDR_TERM  = 5'h1F;

    // Data constants.
    localparam logic [7:0] CTRL_BASE  = 8'h30;
    localparam logic [7:0] FRAME_A    = 8'h40;
    localparam logic [7:0] FRAME_B    = 8'hC0;
    localparam logic [7:0] SWEEP_OFF  = 8'h0F;
    localparam logic [7:0] LO_UP      = 8'hFF;
    localparam logic [7:0] LO_DOWN    = 8'h00;
    localparam logic [7:0] SWEEP_UP   = 8'h87;
    localparam logic [7:0] SWEEP_DOWN = 8'h8F;

    // One control word.
    typedef struct packed {
        logic [4:0]        addr;
        logic [2:0]        dsel;
        logic [7:0]        data;
        logic [1:0]        jmp;
        logic [STEP_W-1:0] target;
        logic              dec;
        logic              last;
    } ucode_t;

    // Sequencer job, latched when a request is taken.
    typedef struct packed {
        logic [7:0]        ctrl;
        logic [2:0]        hi;
        logic [7:0]        lo;
        logic              up;
        logic              same;
        logic [2:0]        cnt;
        logic [STEP_W-1:0] entry;
    } job_t;

    // Microprogram table. Falls through to step + 1 unless the jump is taken.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            STEP_CTRL: w = '{ADDR_CTRL,  DSEL_CTRL,  8'h00,     JMP_SAME,   STEP_LO,  1'b0, 1'b0};
            STEP_HI:   w = '{ADDR_HI,    DSEL_HI,    8'h00,     JMP_ALWAYS, STEP_LO,  1'b0, 1'b0};
            STEP_SW0:  w = '{ADDR_FRAME, DSEL_CONST, FRAME_A,   JMP_NEVER,  STEP_SW0, 1'b0, 1'b0};
            STEP_SW1:  w = '{ADDR_LO,    DSEL_DIR6,  8'h00,     JMP_NEVER,  STEP_SW0, 1'b0, 1'b0};
            STEP_SW2:  w = '{ADDR_SWEEP, DSEL_DIR5,  8'h00,     JMP_NEVER,  STEP_SW0, 1'b0, 1'b0};
            STEP_SW3:  w = '{ADDR_FRAME, DSEL_CONST, FRAME_B,   JMP_NEVER,  STEP_SW0, 1'b0, 1'b0};
            STEP_SW4:  w = '{ADDR_SWEEP, DSEL_CONST, SWEEP_OFF, JMP_MORE,   STEP_SW0, 1'b1, 1'b0};
            STEP_LO:   w = '{ADDR_LO,    DSEL_LO,    8'h00,     JMP_NEVER,  STEP_END, 1'b0, 1'b0};
            STEP_END:  w = '{ADDR_TERM,  DSEL_CONST, 8'h00,     JMP_NEVER,  STEP_END, 1'b0, 1'b1};
            default:   w = '{ADDR_TERM,  DSEL_CONST, 8'h00,     JMP_NEVER,  STEP_END, 1'b0, 1'b1};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/click_free_pulse_period_write_sequencer_unit.sv @@
// A taken request is latched into the job register and step counter of cfps_seq;
// its 2..37 write beats come out of the microcode step counter, one beat a cycle
// unless wr_stall holds the output; the sweep loop repeats five steps.
// The next request is taken once the terminating write is in the output register.
// Reset: asynchronous, active low; clears the current period to zero and idles.
// Depends on cfps_pkg and cfps_seq.
module click_free_pulse_period_write_sequencer_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  cfps_pkg::req_beat_t  req,
    output logic                 wr_valid,
    input  logic                 wr_stall,
    output cfps_pkg::wr_beat_t   wr
);

    logic [10:0]        cur_period_reg;
    logic               wr_valid_reg;
    cfps_pkg::wr_beat_t wr_reg;
    logic               busy;
    logic               accept;
    logic               load;
    cfps_pkg::wr_beat_t beat;
    cfps_pkg::job_t     job;
    logic               direct;
    logic               up;
    logic [2:0]         nhi;
    logic [2:0]         chi;
    logic [2:0]         cnt;

    assign req_stall = busy;
    assign accept    = req_valid && !busy;
    assign load      = busy && (!wr_valid_reg || !wr_stall);

    // Job setup from the request and the installed period
    always_comb
    begin
        direct = req.force_req || !req.notes_active;
        up     = req.new_period > cur_period_reg;
        nhi    = req.new_period[10:8];
        chi    = cur_period_reg[10:8];
        cnt    = up ? (nhi - chi) : (chi - nhi);
        job.ctrl = (cfps_pkg::CTRL_BASE + {4'd0, req.volume}) | {req.duty, 6'd0};
        job.hi   = nhi;
        job.lo   = req.new_period[7:0];
        job.up   = up;
        job.same = (req.new_period == cur_period_reg);
        job.cnt  = cnt;
        priority if (direct)
            job.entry = cfps_pkg::STEP_CTRL;
        else if (cnt != 3'd0)
            job.entry = cfps_pkg::STEP_SW0;
        else
            job.entry = cfps_pkg::STEP_LO;
    end

    cfps_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .job   (job),
        .adv   (load),
        .busy  (busy),
        .beat  (beat)
    );

    // Installed period
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_period_reg <= 11'd0;
        else if (accept)
            cur_period_reg <= req.new_period;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else if (load)
            wr_valid_reg <= 1'b1;
        else if (!wr_stall)
            wr_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            wr_reg <= beat;
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

`ifndef ASSERT_OFF
    // A taken request keeps the input stalled in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("request taken but sequencer not busy");

    // The sequencer goes idle only after loading the terminating write
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_stall) |-> (wr_valid && wr.last))
        else $error("sequencer idle without terminating write");

    // Two terminating writes never follow each other
    a_no_double_last: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid && !wr_stall && wr.last) |=> (!wr_valid || !wr.last))
        else $error("terminating write repeated");

    // The last flag rides only on the terminating register
    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid && wr.last) |-> (wr.reg_addr == cfps_pkg::ADDR_TERM))
        else $error("last flag on wrong register");
`endif

endmodule

@@ hdl/cfps_seq.sv @@
// Microcoded write sequencer: step counter, sweep counter and datapath.
// Depends on cfps_pkg for the job, beat and control word types.
module cfps_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cfps_pkg::job_t  job,
    input  logic            adv,
    output logic            busy,
    output cfps_pkg::wr_beat_t beat
);

    logic [cfps_pkg::STEP_W-1:0] pc_reg, pc_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    cfps_pkg::job_t              job_reg;
    cfps_pkg::ucode_t            uw;
    logic                        take;
    logic [7:0]                  data;

    assign uw = cfps_pkg::ucode_rom(pc_reg);

    // Jump decision
    always_comb
    begin
        unique case (uw.jmp)
            cfps_pkg::JMP_NEVER:  take = 1'b0;
            cfps_pkg::JMP_ALWAYS: take = 1'b1;
            cfps_pkg::JMP_SAME:   take = job_reg.same;
            cfps_pkg::JMP_MORE:   take = (cnt_reg != 3'd1);
            default:              take = 1'b0;
        endcase
    end

    // Data source select
    always_comb
    begin
        unique case (uw.dsel)
            cfps_pkg::DSEL_CONST: data = uw.data;
            cfps_pkg::DSEL_CTRL:  data = job_reg.ctrl;
            cfps_pkg::DSEL_HI:    data = {5'd0, job_reg.hi};
            cfps_pkg::DSEL_LO:    data = job_reg.lo;
            cfps_pkg::DSEL_DIR6:  data = job_reg.up ? cfps_pkg::LO_UP : cfps_pkg::LO_DOWN;
            cfps_pkg::DSEL_DIR5:  data = job_reg.up ? cfps_pkg::SWEEP_UP : cfps_pkg::SWEEP_DOWN;
            default:              data = uw.data;
        endcase
    end

    assign beat = '{reg_addr: uw.addr, reg_data: data, last: uw.last};
    assign busy = busy_reg;

    // Step advance
    always_comb
    begin
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = job.entry;
            cnt_next  = job.cnt;
            busy_next = 1'b1;
        end
        else if (adv)
        begin
            pc_next = take ? uw.target : pc_reg + 1'b1;
            if (uw.dec)
                cnt_next = cnt_reg - 1'b1;
            if (uw.last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= cfps_pkg::STEP_END;
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Job payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
            job_reg <= job;
    end

endmodule
